@@ design/gdv_pkg.sv @@
package gdv_pkg;

  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int PORT_W     = 7;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_DFS  = 2'd1;
  localparam logic [1:0] CMD_BFS  = 2'd2;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_START_NODE = 1'b1;

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_DFS  = 2'd1,
    OP_BFS  = 2'd2
  } op_t;

  typedef logic [MAX_NODES-1:0] row_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } item_t;

  function automatic row_t bit_of(input logic [NODE_W-1:0] idx);
    row_t v;
    v      = '0;
    v[idx] = 1'b1;
    return v;
  endfunction

  function automatic logic [NODE_W-1:0] lowest_idx(input row_t v);
    row_t              iso;
    logic [NODE_W-1:0] idx;
    iso = v & (~v + row_t'(1));
    idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (iso[i]) idx = idx | NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ design/gdv_front.sv @@
module gdv_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        full,
  input  logic [1:0]                  cmd,
  input  logic [gdv_pkg::PORT_W-1:0]  node_a,
  input  logic [gdv_pkg::PORT_W-1:0]  node_b,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [gdv_pkg::PORT_W-1:0]  cfg_data,
  output logic                        push,
  output gdv_pkg::item_t              item,
  output gdv_pkg::row_t               live
);
  import gdv_pkg::*;

  logic [PORT_W-1:0] node_count;
  logic [PORT_W-1:0] start_node;
  logic [PORT_W-1:0] n_eff;
  logic [PORT_W-1:0] a_m1;
  logic [PORT_W-1:0] b_m1;
  logic [PORT_W-1:0] s_m1;
  logic              a_ok;
  logic              b_ok;
  logic              s_ok;
  logic              accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= PORT_W'(1);
      start_node <= PORT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_START_NODE: start_node <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = (node_count > PORT_W'(MAX_NODES)) ? PORT_W'(MAX_NODES) : node_count;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      live[i] = (PORT_W'(i) < n_eff);
    end
  end

  assign a_m1 = node_a - PORT_W'(1);
  assign b_m1 = node_b - PORT_W'(1);
  assign s_m1 = start_node - PORT_W'(1);
  assign a_ok = (node_a != '0) && (node_a <= n_eff);
  assign b_ok = (node_b != '0) && (node_b <= n_eff);
  assign s_ok = (start_node != '0) && (start_node <= n_eff);

  assign accept = start && !full;

  always_comb begin
    push   = 1'b0;
    item.op = OP_EDGE;
    item.a = a_m1[NODE_W-1:0];
    item.b = b_m1[NODE_W-1:0];
    case (cmd)
      CMD_EDGE: begin
        push = accept && a_ok && b_ok;
      end
      CMD_DFS: begin
        push    = accept && s_ok;
        item.op = OP_DFS;
        item.a  = s_m1[NODE_W-1:0];
      end
      CMD_BFS: begin
        push    = accept && s_ok;
        item.op = OP_BFS;
        item.a  = s_m1[NODE_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

@@ design/gdv_cmd_fifo.sv @@
module gdv_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gdv_pkg::item_t  din,
  input  logic            pop,
  output gdv_pkg::item_t  dout,
  output logic            full,
  output logic            empty
);
  import gdv_pkg::*;

  item_t              slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wrp;
  logic [FIFO_AW-1:0] rdp;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rdp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wrp   <= '0;
      rdp   <= '0;
      count <= '0;
    end else begin
      if (push) wrp <= wrp + FIFO_AW'(1);
      if (pop)  rdp <= rdp + FIFO_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wrp] <= din;
  end

endmodule

@@ design/gdv_walk.sv @@
module gdv_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  gdv_pkg::row_t               live,
  input  gdv_pkg::item_t              fifo_item,
  input  logic                        fifo_empty,
  output logic                        pop,
  output logic                        strobe,
  output logic [gdv_pkg::PORT_W-1:0]  node,
  output logic                        walk_kind,
  output logic                        last
);
  import gdv_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_EA    = 10'b00_0000_0010,
    S_EB    = 10'b00_0000_0100,
    S_EW    = 10'b00_0000_1000,
    S_DSCAN = 10'b00_0001_0000,
    S_DPOP  = 10'b00_0010_0000,
    S_BDEQ  = 10'b00_0100_0000,
    S_BWAIT = 10'b00_1000_0000,
    S_BSCAN = 10'b01_0000_0000,
    S_BENQ  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  item_t  cur;

  row_t              adj_mem [MAX_NODES];
  row_t              row_valid;
  row_t              adj_rdata;
  logic              adj_rv;
  logic [NODE_W-1:0] adj_raddr;
  logic              adj_we;
  logic [NODE_W-1:0] adj_waddr;
  row_t              adj_wdata;
  row_t              row;

  logic [NODE_W-1:0] stk_mem [MAX_NODES];
  logic [NODE_W-1:0] stk_rdata;
  logic [CNT_W-1:0]  stk_raddr;
  logic              s_we;
  logic [NODE_W-1:0] s_waddr;

  logic [NODE_W-1:0] que_mem [MAX_NODES];
  logic [NODE_W-1:0] que_rdata;
  logic              q_we;
  logic [NODE_W-1:0] q_waddr;

  logic [NODE_W-1:0] mem_wdata;

  row_t              seen, seen_next;
  row_t              cand, cand_next;
  row_t              cand_now;
  row_t              pe_in;
  logic [NODE_W-1:0] low;
  logic [CNT_W-1:0]  top, top_next;
  logic [CNT_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  tail, tail_next;

  logic              emit;
  logic [NODE_W-1:0] emit_idx;
  logic              finish;
  logic [NODE_W-1:0] hold;
  logic              hold_v;

  assign row       = adj_rv ? adj_rdata : '0;
  assign cand_now  = row & live & ~seen;
  assign pe_in     = (state == S_BENQ) ? cand : cand_now;
  assign low       = lowest_idx(pe_in);
  assign stk_raddr = top - CNT_W'(2);

  always_comb begin
    state_next = state;
    seen_next  = seen;
    cand_next  = cand;
    top_next   = top;
    head_next  = head;
    tail_next  = tail;
    pop        = 1'b0;
    adj_raddr  = cur.a;
    adj_we     = 1'b0;
    adj_waddr  = cur.a;
    adj_wdata  = row | bit_of(cur.b);
    s_we       = 1'b0;
    s_waddr    = top[NODE_W-1:0];
    q_we       = 1'b0;
    q_waddr    = tail[NODE_W-1:0];
    mem_wdata  = low;
    emit       = 1'b0;
    emit_idx   = low;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        adj_raddr = fifo_item.a;
        if (!fifo_empty) begin
          pop = 1'b1;
          case (fifo_item.op)
            OP_EDGE: state_next = S_EA;
            OP_DFS: begin
              seen_next  = bit_of(fifo_item.a);
              emit       = 1'b1;
              emit_idx   = fifo_item.a;
              s_we       = 1'b1;
              s_waddr    = '0;
              mem_wdata  = fifo_item.a;
              top_next   = CNT_W'(1);
              state_next = S_DSCAN;
            end
            OP_BFS: begin
              seen_next  = bit_of(fifo_item.a);
              q_we       = 1'b1;
              q_waddr    = '0;
              mem_wdata  = fifo_item.a;
              head_next  = '0;
              tail_next  = CNT_W'(1);
              state_next = S_BDEQ;
            end
            default: pop = 1'b0;
          endcase
        end
      end
      S_EA: begin
        adj_we     = 1'b1;
        state_next = S_EB;
      end
      S_EB: begin
        adj_raddr  = cur.b;
        state_next = S_EW;
      end
      S_EW: begin
        adj_we     = 1'b1;
        adj_waddr  = cur.b;
        adj_wdata  = row | bit_of(cur.a);
        state_next = S_IDLE;
      end
      S_DSCAN: begin
        if (cand_now != '0) begin
          seen_next = seen | bit_of(low);
          emit      = 1'b1;
          s_we      = 1'b1;
          top_next  = top + CNT_W'(1);
          adj_raddr = low;
        end else begin
          top_next = top - CNT_W'(1);
          if (top == CNT_W'(1)) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_DPOP;
          end
        end
      end
      S_DPOP: begin
        adj_raddr  = stk_rdata;
        state_next = S_DSCAN;
      end
      S_BDEQ: begin
        head_next  = head + CNT_W'(1);
        state_next = S_BWAIT;
      end
      S_BWAIT: begin
        emit       = 1'b1;
        emit_idx   = que_rdata;
        adj_raddr  = que_rdata;
        state_next = S_BSCAN;
      end
      S_BSCAN: begin
        cand_next  = cand_now;
        state_next = S_BENQ;
      end
      S_BENQ: begin
        if (cand != '0) begin
          cand_next = cand & (cand - row_t'(1));
          seen_next = seen | bit_of(low);
          q_we      = 1'b1;
          tail_next = tail + CNT_W'(1);
        end else if (head != tail) begin
          state_next = S_BDEQ;
        end else begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      hold_v <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (emit && hold_v) || finish;
      if (emit)   hold_v <= 1'b1;
      if (finish) hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    seen <= seen_next;
    cand <= cand_next;
    top  <= top_next;
    head <= head_next;
    tail <= tail_next;
    if (pop)  cur  <= fifo_item;
    if (emit) hold <= emit_idx;
    if ((emit && hold_v) || finish) begin
      node      <= PORT_W'(hold) + PORT_W'(1);
      walk_kind <= (cur.op == OP_BFS);
      last      <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (adj_we) begin
      row_valid[adj_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata <= adj_mem[adj_raddr];
    adj_rv    <= row_valid[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) stk_mem[s_waddr] <= mem_wdata;
    stk_rdata <= stk_mem[stk_raddr[NODE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_we) que_mem[q_waddr] <= mem_wdata;
    que_rdata <= que_mem[head[NODE_W-1:0]];
  end

endmodule

@@ design/graph_dfs_bfs_visit_order.sv @@
// Channel   Direction  Signals                               Transaction
// command   in         start, busy, cmd, node_a, node_b      start && !busy
// config    in         cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//                      cfg_data
// result    out        strobe, node, walk_kind, last         strobe, one cycle each
//
// Commands pass through a two-entry queue; busy is high while it is full.
// Edge load runs through walk states S_EA, S_EB and S_EW. A depth-first run emits each
// vertex as found and backtracks via S_DPOP; a breadth-first run takes each dequeued
// vertex through S_BDEQ, S_BWAIT and S_BSCAN, then queues its neighbours in S_BENQ.
// Reset clears the graph through per-row valid flags.
// Results cannot be stalled; each is presented for exactly one cycle.
module graph_dfs_bfs_visit_order (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [6:0]  node_a,
  input  logic [6:0]  node_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        strobe,
  output logic [6:0]  node,
  output logic        walk_kind,
  output logic        last
);
  import gdv_pkg::*;

  item_t push_item;
  item_t pop_item;
  row_t  live;
  logic  fifo_push;
  logic  fifo_pop;
  logic  fifo_full;
  logic  fifo_empty;

  assign busy = fifo_full;

  gdv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .full      (fifo_full),
    .cmd       (cmd),
    .node_a    (node_a),
    .node_b    (node_b),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (fifo_push),
    .item      (push_item),
    .live      (live)
  );

  gdv_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .din   (push_item),
    .pop   (fifo_pop),
    .dout  (pop_item),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  gdv_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .live       (live),
    .fifo_item  (pop_item),
    .fifo_empty (fifo_empty),
    .pop        (fifo_pop),
    .strobe     (strobe),
    .node       (node),
    .walk_kind  (walk_kind),
    .last       (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    fifo_full |-> !fifo_push)
    else $error("command pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from empty queue");

  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (node != 7'd0 && node <= 7'(MAX_NODES)))
    else $error("result vertex out of range");

  a_push_has_valid_op: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> (push_item.op == OP_EDGE || push_item.op == OP_DFS ||
                   push_item.op == OP_BFS) && !(start && busy))
    else $error("bad command queued");

endmodule
